@@ design/sha_pkg.sv @@
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [0:63];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[i];
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h [0:7];
        h = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
        };
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ design/sha_ram.sv @@
module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/sha_core.sv @@
module sha_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        init,
    output logic        busy,
    output logic [5:0]  buf_raddr,
    input  logic [7:0]  buf_rdata,
    input  logic [2:0]  hout_idx,
    output logic [31:0] hout
);
    import sha_pkg::*;

    // phase: 0 idle, 1 load words, 2 rounds, 3 chain add
    logic [1:0]  phase_reg, phase_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] h_reg [0:7];
    logic [31:0] v_reg [0:7];
    logic [31:0] w_reg [0:15];
    logic [31:0] wbuild_reg;
    logic [31:0] s0, s1, wnew, t1, t2, wr;
    logic        rd_valid_reg;

    assign busy = (phase_reg != 2'd0);
    assign hout = h_reg[hout_idx];
    assign buf_raddr = cnt_reg[5:0];

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        case (phase_reg)
            2'd0:
            begin
                if (start)
                begin
                    phase_next = 2'd1;
                    cnt_next = '0;
                end
            end
            2'd1:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd64)
                begin
                    phase_next = 2'd2;
                    cnt_next = '0;
                end
            end
            2'd2:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    phase_next = 2'd3;
                end
            end
            default:
            begin
                phase_next = 2'd0;
            end
        endcase
    end

    assign s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wnew = w_reg[0] + s0 + w_reg[9] + s1;
    assign wr = (cnt_reg < 7'd16) ? w_reg[cnt_reg[3:0]] : w_reg[15];
    assign t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
        + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(cnt_reg[5:0]) + wr;
    assign t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
        + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_h(3'(i));
            end
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
            rd_valid_reg <= (phase_reg == 2'd1) && (cnt_reg < 7'd64);
            if (init)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= init_h(3'(i));
                end
            end
            else if (phase_reg == 2'd3)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == 2'd1 && rd_valid_reg)
        begin
            wbuild_reg <= {wbuild_reg[23:0], buf_rdata};
            if (cnt_reg[1:0] == 2'd0)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= {wbuild_reg[23:0], buf_rdata};
            end
        end
        if (phase_reg == 2'd1 && cnt_reg == 7'd64)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        if (phase_reg == 2'd2)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            if (cnt_reg >= 7'd15)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= wnew;
            end
        end
    end

    property p_start_idle;
        @(posedge clk) disable iff (!rst_n) start |-> !busy;
    endproperty
    assert property (p_start_idle) else $error("start while busy");

    property p_load_to_round;
        @(posedge clk) disable iff (!rst_n)
            (phase_reg == 2'd1 && cnt_reg == 7'd64) |=> (phase_reg == 2'd2 && cnt_reg == 7'd0);
    endproperty
    assert property (p_load_to_round) else $error("load did not end in rounds");

    property p_round_end;
        @(posedge clk) disable iff (!rst_n)
            (phase_reg == 2'd2 && cnt_reg == 7'd63) |=> (phase_reg == 2'd3);
    endproperty
    assert property (p_round_end) else $error("rounds did not end in chain add");

endmodule

@@ design/sha256_stream_hasher.sv @@
// sha-256 hasher for a byte stream
// s_axis: one request per message item, tuser = kind (0 byte, 1 finish),
//   tdata = message byte
// m_axis: eight digest words per finish, tdata = word, tuser = word index,
//   tlast on the eighth word
// a byte request is written straight into the buffer ram; every 64th byte starts a
// compression that holds s_axis_tready low until it is done (64 buffer reads
// through the single block ram read port, then 64 rounds of the single round unit)
// finish writes the padding bytes one a cycle into the buffer, pausing during
// each compression that starts when the buffer fills, then offers the eight words
// the digest takes one word a cycle while m_axis_tready is high; a stall
// just holds the current word and no new request is taken until all
// eight words are gone, after which the hasher is ready for a new message
// reset returns the chaining words to the initial values and clears the
// byte counters; the buffer ram needs no clearing
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);
    import sha_pkg::*;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] msg_reg, msg_next;
    logic [63:0] bits_reg, bits_next;
    logic [2:0]  widx_reg, widx_next;
    logic        len_reg, len_next;
    logic        we, start, init, busy;
    logic [7:0]  wdata;
    logic [5:0]  raddr;
    logic [7:0]  rdata;
    logic        acc;

    sha_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
        .clk(clk), .we(we), .waddr(fill_reg), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    sha_core u_core (
        .clk(clk), .rst_n(rst_n), .start(start), .init(init), .busy(busy),
        .buf_raddr(raddr), .buf_rdata(rdata), .hout_idx(widx_reg), .hout(m_axis_tdata)
    );

    assign acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && !busy;
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tuser = widx_reg;
    assign m_axis_tlast = (widx_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        msg_next = msg_reg;
        bits_next = bits_reg;
        widx_next = widx_reg;
        len_next = len_reg;
        we = 1'b0;
        wdata = s_axis_tdata;
        start = 1'b0;
        init = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && !s_axis_tuser)
                begin
                    we = 1'b1;
                    fill_next = fill_reg + 6'd1;
                    msg_next = msg_reg + 61'd1;
                    start = (fill_reg == 6'd63);
                end
                else if (acc)
                begin
                    we = 1'b1;
                    wdata = PAD_BYTE;
                    bits_next = {msg_reg, 3'b000};
                    fill_next = fill_reg + 6'd1;
                    start = (fill_reg == 6'd63);
                    len_next = (fill_reg == 6'd55);
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (!busy)
                begin
                    we = 1'b1;
                    fill_next = fill_reg + 6'd1;
                    start = (fill_reg == 6'd63);
                    if (len_reg)
                    begin
                        wdata = bits_reg[63:56];
                        bits_next = {bits_reg[55:0], 8'h00};
                        if (fill_reg == 6'd63)
                        begin
                            state_next = ST_ROUND;
                        end
                    end
                    else
                    begin
                        wdata = 8'h00;
                        if (fill_reg == 6'd55)
                        begin
                            len_next = 1'b1;
                        end
                    end
                end
            end
            ST_ROUND:
            begin
                if (!busy && !start)
                begin
                    state_next = ST_EMIT;
                    widx_next = '0;
                end
            end
            ST_EMIT:
            begin
                if (m_axis_tready)
                begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == 3'd7)
                    begin
                        init = 1'b1;
                        msg_next = '0;
                        fill_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            msg_reg <= '0;
            widx_reg <= '0;
            len_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            msg_reg <= msg_next;
            widx_reg <= widx_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
    end

    property p_no_req_in_emit;
        @(posedge clk) disable iff (!rst_n) m_axis_tvalid |-> !s_axis_tready;
    endproperty
    assert property (p_no_req_in_emit) else $error("request taken during digest");

    property p_emit_core_idle;
        @(posedge clk) disable iff (!rst_n) m_axis_tvalid |-> !busy;
    endproperty
    assert property (p_emit_core_idle) else $error("digest while compressing");

    property p_last_returns_idle;
        @(posedge clk) disable iff (!rst_n)
            (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (state_reg == ST_IDLE);
    endproperty
    assert property (p_last_returns_idle) else $error("no return to idle after digest");

endmodule

@@ sim/tb_sha256_stream_hasher.sv @@
`timescale 1ns / 100ps

module tb_sha256_stream_hasher;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;
    localparam int   CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    class digest_scoreboard;
        logic [31:0]  chain [8];
        logic [7:0]   block [64];
        int unsigned  fill;
        logic [60:0]  msg_len;
        digest_word_t pending [$];
        int unsigned  mismatches;
        int unsigned  words_checked;
        int unsigned  messages;

        function new();
            mismatches = 0;
            words_checked = 0;
            messages = 0;
            clear();
        endfunction

        function void clear();
            chain[0] = 32'h6a09e667; chain[1] = 32'hbb67ae85;
            chain[2] = 32'h3c6ef372; chain[3] = 32'ha54ff53a;
            chain[4] = 32'h510e527f; chain[5] = 32'h9b05688c;
            chain[6] = 32'h1f83d9ab; chain[7] = 32'h5be0cd19;
            fill = 0;
            msg_len = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] k [64];
            logic [31:0] w [64];
            logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
            k = '{
                32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
                32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
                32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
                32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
                32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
                32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
                32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
                32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
                32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
                32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
                32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
                32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
            };
            for (int i = 0; i < 16; i++)
                w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
            for (int i = 16; i < 64; i++)
                w[i] = w[i-16] + w[i-7]
                     + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                     + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
            for (int i = 0; i < 64; i++)
            begin
                t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
                   + ((e & f) ^ (~e & g)) + k[i] + w[i];
                t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
                   + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
            chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
        endfunction

        function void absorb(logic [7:0] b);
            block[fill] = b;
            fill = (fill + 1) % 64;
            if (fill == 0)
                compress();
        endfunction

        function void note_request(logic kind, logic [7:0] data);
            logic [63:0] bits;
            digest_word_t dw;
            if (kind == KIND_BYTE)
            begin
                absorb(data);
                msg_len = msg_len + 1'b1;
                return;
            end
            bits = {msg_len, 3'b000};
            absorb(8'h80);
            while (fill != 56)
                absorb(8'h00);
            for (int i = 7; i >= 0; i--)
                absorb(bits[8*i +: 8]);
            for (int i = 0; i < 8; i++)
            begin
                dw.word = chain[i];
                dw.index = i[2:0];
                dw.last = (i == 7);
                pending.push_back(dw);
            end
            messages++;
            clear();
        endfunction

        function void check_word(digest_word_t got);
            digest_word_t exp;
            words_checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest word %h idx %0d last %0b",
                             got.word, got.index, got.last);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                             exp.word, exp.index, exp.last,
                             got.word, got.index, got.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    digest_scoreboard sb;
    int unsigned cycles;
    int unsigned requests_sent;
    int unsigned gap_left;
    bit          hold_off;
    bit          stall_on;

    sha256_stream_hasher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        sb = new();
        cycles = 0;
        requests_sent = 0;
        gap_left = 0;
        hold_off = 0;
        stall_on = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_BYTE;
        m_axis_tready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // receiver: own stall pattern, plus a long hold-off window
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word('{m_axis_tdata, m_axis_tuser, m_axis_tlast});
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off)
            m_axis_tready <= 1'b0;
        else if (stall_on)
            m_axis_tready <= ($urandom_range(0, 3) == 0);
        else
            m_axis_tready <= 1'b1;
        if ($urandom_range(0, 40) == 0)
            stall_on <= ~stall_on;
    end

    initial
    begin
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    // sends one request, with bursty gaps before it
    task automatic send_request(input logic kind, input logic [7:0] data);
        if (gap_left == 0 && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 12);
        while (gap_left > 0)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            gap_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(kind, data);
        requests_sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_request(KIND_BYTE, 8'($urandom));
        send_request(KIND_FINISH, 8'($urandom));
    endtask

    initial
    begin
        int unsigned wait_cycles;
        @(posedge rst_n);
        @(posedge clk);
        // directed: empty message, "abc", extremes
        send_request(KIND_FINISH, 8'hff);
        send_request(KIND_BYTE, "a");
        send_request(KIND_BYTE, "b");
        send_request(KIND_BYTE, "c");
        send_request(KIND_FINISH, 8'h00);
        send_request(KIND_BYTE, 8'h00);
        send_request(KIND_BYTE, 8'hff);
        send_request(KIND_BYTE, 8'h55);
        send_request(KIND_BYTE, 8'haa);
        send_request(KIND_FINISH, 8'h00);
        // padding boundaries: 56 and 63 byte messages
        send_message(56);
        send_message(63);
        // a few short random messages
        while (requests_sent < 136)
            send_message($urandom_range(0, 4));
        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        $display("sent %0d requests in %0d messages, checked %0d digest words",
                 requests_sent, sb.messages, sb.words_checked);
        $display("padding boundaries, empty message, and a long output stall covered");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches, %0d words missing", sb.mismatches, sb.pending.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
